[sv/bdr_pkg.sv]
`default_nettype none

package bdr_pkg;

  // Fixed field widths.
  localparam int CH_W       = 8;
  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 12;
  localparam int HGT_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  // Configuration port.
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_FACTOR_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [CFG_FACTOR_W-1:0] FACTOR_RST = 4'd2;
  localparam logic [CFG_DATA_W-1:0]   WIDTH_RST  = 13'd1024;
  localparam logic [HGT_W-1:0]        HEIGHT_RST = 13'd1024;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [OCOL_W-1:0] out_column;
    logic [ROW_W-1:0]  out_row;
    logic              frame_done;
  } out_pix_t;

  // Classification of one kept source pixel, handed from front to back.
  typedef struct packed {
    logic             first;
    logic             emit;
    logic             frame_done;
    logic [ROW_W-1:0] out_row;
  } work_meta_t;

endpackage

`default_nettype wire

[sv/bdr_fifo.sv]
`default_nettype none

module bdr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty,
  output logic      [CNTW-1:0]  count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[sv/bdr_front.sv]
`default_nettype none

module bdr_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_FACTOR = 8,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int FW = $clog2(MAX_FACTOR + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [bdr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bdr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                acc,
  input  wire bdr_pkg::in_pix_t                    pix,
  output logic                                     wk_valid,
  output logic [CW-1:0]                            wk_col,
  output bdr_pkg::work_meta_t                      wk_meta,
  output bdr_pkg::in_pix_t                         wk_pix,
  output logic [FW-1:0]                            eff_f
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CX  = WW + 2;
  localparam int RX  = bdr_pkg::HGT_W + 2;
  localparam int FBW = $clog2(MAX_FACTOR);
  localparam int HW  = bdr_pkg::HGT_W;
  localparam int RW  = bdr_pkg::ROW_W;

  logic [bdr_pkg::CFG_FACTOR_W-1:0] factor_r;
  logic [bdr_pkg::CFG_DATA_W-1:0]   width_r;
  logic [HW-1:0]                    height_r;

  logic [CW-1:0]  col_r, col_nxt, cbase_r, cbase_nxt, ocol_r, ocol_nxt;
  logic [FBW-1:0] cib_r, cib_nxt, rib_r, rib_nxt;
  logic [RW-1:0]  row_r, row_nxt, rbase_r, rbase_nxt, orow_r, orow_nxt;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          restart;
  logic          col_fit, col_last, row_fit, row_last;
  logic          col_end, cib_end, row_end, rib_end;

  // Out-of-range register values saturate; zero acts as one.
  always_comb begin
    if (factor_r == '0) begin
      eff_f = FW'(1);
    end else if (32'(factor_r) > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_r);
    end
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_r) > bdr_pkg::MAX_HEIGHT) begin
      eff_h = HW'(bdr_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  always_comb begin
    case (cfg_index)
      bdr_pkg::CFG_FACTOR: restart = cfg_we;
      bdr_pkg::CFG_WIDTH:  restart = cfg_we;
      bdr_pkg::CFG_HEIGHT: restart = cfg_we;
      default:             restart = 1'b0;
    endcase
  end

  // A block is whole when its base plus one factor stays inside the image;
  // it is the last of its row or column when a further block would not fit.
  assign col_fit  = (CX'(cbase_r) + CX'(eff_f)) <= CX'(eff_w);
  assign col_last = (CX'(cbase_r) + CX'(eff_f) + CX'(eff_f)) > CX'(eff_w);
  assign row_fit  = (RX'(rbase_r) + RX'(eff_f)) <= RX'(eff_h);
  assign row_last = (RX'(rbase_r) + RX'(eff_f) + RX'(eff_f)) > RX'(eff_h);

  assign col_end = (WW'(col_r) + WW'(1)) >= eff_w;
  assign cib_end = (FW'(cib_r) + FW'(1)) >= eff_f;
  assign row_end = (HW'(row_r) + HW'(1)) >= eff_h;
  assign rib_end = (FW'(rib_r) + FW'(1)) >= eff_f;

  assign wk_valid           = acc && col_fit && row_fit;
  assign wk_col             = ocol_r;
  assign wk_pix             = pix;
  assign wk_meta.first      = (cib_r == '0) && (rib_r == '0);
  assign wk_meta.emit       = cib_end && rib_end;
  assign wk_meta.frame_done = col_last && row_last;
  assign wk_meta.out_row    = orow_r;

  always_comb begin
    col_nxt   = col_r;
    cib_nxt   = cib_r;
    cbase_nxt = cbase_r;
    ocol_nxt  = ocol_r;
    row_nxt   = row_r;
    rib_nxt   = rib_r;
    rbase_nxt = rbase_r;
    orow_nxt  = orow_r;
    if (col_end) begin
      col_nxt   = '0;
      cib_nxt   = '0;
      cbase_nxt = '0;
      ocol_nxt  = '0;
      if (row_end) begin
        row_nxt   = '0;
        rib_nxt   = '0;
        rbase_nxt = '0;
        orow_nxt  = '0;
      end else begin
        row_nxt = row_r + RW'(1);
        if (rib_end) begin
          rib_nxt   = '0;
          rbase_nxt = row_r + RW'(1);
          orow_nxt  = orow_r + RW'(1);
        end else begin
          rib_nxt = rib_r + FBW'(1);
        end
      end
    end else begin
      col_nxt = col_r + CW'(1);
      if (cib_end) begin
        cib_nxt   = '0;
        cbase_nxt = col_r + CW'(1);
        ocol_nxt  = ocol_r + CW'(1);
      end else begin
        cib_nxt = cib_r + FBW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= bdr_pkg::FACTOR_RST;
      width_r  <= bdr_pkg::WIDTH_RST;
      height_r <= bdr_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdr_pkg::CFG_FACTOR: factor_r <= cfg_data[bdr_pkg::CFG_FACTOR_W-1:0];
        bdr_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        bdr_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      cib_r   <= '0;
      cbase_r <= '0;
      ocol_r  <= '0;
      row_r   <= '0;
      rib_r   <= '0;
      rbase_r <= '0;
      orow_r  <= '0;
    end else if (acc) begin
      col_r   <= col_nxt;
      cib_r   <= cib_nxt;
      cbase_r <= cbase_nxt;
      ocol_r  <= ocol_nxt;
      row_r   <= row_nxt;
      rib_r   <= rib_nxt;
      rbase_r <= rbase_nxt;
      orow_r  <= orow_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/bdr_back.sv]
`default_nettype none

module bdr_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_FACTOR = 8,
  parameter int OUT_DEPTH = 8,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int FW = $clog2(MAX_FACTOR + 1),
  localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [FW-1:0]        eff_f,
  input  wire logic                 wk_valid,
  input  wire logic [CW-1:0]        wk_col,
  input  wire bdr_pkg::work_meta_t  wk_meta,
  input  wire bdr_pkg::in_pix_t     wk_pix,
  output logic                      wk_pop,
  input  wire logic [OCW-1:0]       out_cnt,
  output logic                      res_valid,
  output bdr_pkg::out_pix_t         res
);

  localparam int CHW = bdr_pkg::CH_W;
  localparam int SW  = CHW + 2 * $clog2(MAX_FACTOR);
  localparam int K   = SW;
  localparam int RCW = K + 1;
  localparam int PW  = SW + RCW;
  localparam int NW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int CKW = CHW + 1 + NW;

  // Reciprocal and square of every factor, fixed at elaboration.
  logic [RCW-1:0] recip_tab [MAX_FACTOR+1];
  logic [NW-1:0]  nsq_tab   [MAX_FACTOR+1];

  for (genvar gi = 0; gi <= MAX_FACTOR; gi++) begin : g_tab
    if (gi == 0) begin : g_zero
      assign recip_tab[gi] = '0;
      assign nsq_tab[gi]   = '0;
    end else begin : g_val
      localparam int RECIP = (1 << K) / (gi * gi);
      assign recip_tab[gi] = RCW'(RECIP);
      assign nsq_tab[gi]   = NW'(gi * gi);
    end
  end

  logic [RCW-1:0] recip;
  logic [NW-1:0]  nsq;
  assign recip = recip_tab[eff_f];
  assign nsq   = nsq_tab[eff_f];

  logic [2:0][SW-1:0] mem [MAX_WIDTH];
  logic [2:0][SW-1:0] rd_r;

  logic                s1_v_r;
  logic [CW-1:0]       s1_col_r;
  bdr_pkg::work_meta_t s1_meta_r;
  bdr_pkg::in_pix_t    s1_pix_r;

  logic               fwd_v_r;
  logic [CW-1:0]      fwd_col_r;
  logic [2:0][SW-1:0] fwd_sum_r;

  logic                s2_v_r;
  logic [2:0][SW-1:0]  s2_sum_r;
  logic [CW-1:0]       s2_col_r;
  bdr_pkg::work_meta_t s2_meta_r;

  logic                 s3_v_r;
  logic [2:0][SW-1:0]   s3_sum_r;
  logic [2:0][CHW-1:0]  s3_q0_r;
  logic [CW-1:0]        s3_col_r;
  bdr_pkg::work_meta_t  s3_meta_r;

  logic [2:0][SW-1:0]  base_c, pix_c, sum_c;
  logic [2:0][PW-1:0]  prod_c;
  logic [2:0][CHW-1:0] q0_c, q_c;
  logic [2:0][CKW-1:0] chk_c;
  logic [1:0]          inflight;

  // Every stage past the queue head that may still produce a result holds
  // a slot of the result queue in reserve, so the pipeline never stalls.
  assign inflight = 2'(s1_v_r && s1_meta_r.emit) + 2'(s2_v_r) + 2'(s3_v_r);
  assign wk_pop   = wk_valid && ((32'(out_cnt) + 32'(inflight)) < OUT_DEPTH);

  // The memory read misses the write of the pixel just ahead; that sum
  // comes from the bypass register instead.
  always_comb begin
    base_c   = (fwd_v_r && (fwd_col_r == s1_col_r)) ? fwd_sum_r : rd_r;
    pix_c[0] = SW'(s1_pix_r.red_in);
    pix_c[1] = SW'(s1_pix_r.green_in);
    pix_c[2] = SW'(s1_pix_r.blue_in);
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = s1_meta_r.first ? pix_c[i] : base_c[i] + pix_c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = PW'(s2_sum_r[i]) * PW'(recip);
      q0_c[i]   = prod_c[i][K+CHW-1:K];
    end
  end

  // The reciprocal estimate is at most one low; one compare corrects it.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chk_c[i] = (CKW'(s3_q0_r[i]) + CKW'(1)) * CKW'(nsq);
      q_c[i]   = s3_q0_r[i] + CHW'(CKW'(s3_sum_r[i]) >= chk_c[i]);
    end
  end

  assign res_valid      = s3_v_r;
  assign res.red_out    = q_c[0];
  assign res.green_out  = q_c[1];
  assign res.blue_out   = q_c[2];
  assign res.out_column = bdr_pkg::OCOL_W'(s3_col_r);
  assign res.out_row    = s3_meta_r.out_row;
  assign res.frame_done = s3_meta_r.frame_done;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_col_r] <= sum_c;
    end
    rd_r <= mem[wk_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      s1_v_r  <= wk_pop;
      fwd_v_r <= s1_v_r;
      s2_v_r  <= s1_v_r && s1_meta_r.emit;
      s3_v_r  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r  <= wk_col;
    s1_meta_r <= wk_meta;
    s1_pix_r  <= wk_pix;
    fwd_col_r <= s1_col_r;
    fwd_sum_r <= sum_c;
    s2_sum_r  <= sum_c;
    s2_col_r  <= s1_col_r;
    s2_meta_r <= s1_meta_r;
    s3_sum_r  <= s2_sum_r;
    s3_q0_r   <= q0_c;
    s3_col_r  <= s2_col_r;
    s3_meta_r <= s2_meta_r;
  end

endmodule

`default_nettype wire

[sv/box_downsample_rgb.sv]
// Box-filter downsampler for a raster-order RGB pixel stream. Each square
// block of block_factor by block_factor source pixels becomes one output
// pixel holding the truncated average of each channel, its column and row
// in the reduced image, and a flag on the last pixel of the frame.
// Input side: a source pixel transfers when in_push is high and in_full is
// low. Result side: the oldest result sits on out_data while out_empty is
// low and transfers when out_pop is high. One pixel is taken every cycle
// while in_full is low; the per-column sum memory is read and written once
// per cycle, which sets that rate. A result follows its block's bottom-right
// pixel. While the receiver stalls, pixels keep flowing until the result
// queue and its reserved slots fill, after which in_full rises.
// Configuration writes (cfg_we, cfg_index, cfg_data) to any defined register
// restart the frame; they are meant for an idle block. After reset the
// factor is 2 and the image is 1024 by 1024. The sum memory needs no
// clearing pass, since each block's first pixel overwrites its column sum.
`default_nettype none

module box_downsample_rgb #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire bdr_pkg::in_pix_t                in_data,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output bdr_pkg::out_pix_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [bdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bdr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int FW         = $clog2(MAX_FACTOR + 1);
  localparam int WORK_DEPTH = 4;
  localparam int OUT_DEPTH  = 8;
  localparam int OCW        = $clog2(OUT_DEPTH + 1);
  localparam int WK_W       = CW + $bits(bdr_pkg::work_meta_t) + $bits(bdr_pkg::in_pix_t);
  localparam int RES_W      = $bits(bdr_pkg::out_pix_t);

  logic                in_acc;
  logic                f_valid;
  logic [CW-1:0]       f_col;
  bdr_pkg::work_meta_t f_meta;
  bdr_pkg::in_pix_t    f_pix;
  logic [FW-1:0]       eff_f;

  logic [WK_W-1:0]     wq_wdata, wq_rdata;
  logic                wq_full, wq_empty, wq_pop;

  logic [CW-1:0]       b_col;
  bdr_pkg::work_meta_t b_meta;
  bdr_pkg::in_pix_t    b_pix;

  logic                res_valid;
  bdr_pkg::out_pix_t   res;
  logic [RES_W-1:0]    oq_rdata;
  logic [OCW-1:0]      oq_cnt;

  // Dropped pixels still count as transfers; they only move the counters.
  assign in_acc  = in_push && !wq_full;
  assign in_full = wq_full;

  bdr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (in_acc),
    .pix       (in_data),
    .wk_valid  (f_valid),
    .wk_col    (f_col),
    .wk_meta   (f_meta),
    .wk_pix    (f_pix),
    .eff_f     (eff_f)
  );

  assign wq_wdata = {f_col, f_meta, f_pix};

  // Short work queue between the classifier and the accumulator.
  bdr_fifo #(
    .WIDTH (WK_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data (wq_wdata),
    .rd_en   (wq_pop),
    .rd_data (wq_rdata),
    .full    (wq_full),
    .empty   (wq_empty),
    .count   ()
  );

  assign {b_col, b_meta, b_pix} = wq_rdata;

  bdr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_f     (eff_f),
    .wk_valid  (!wq_empty),
    .wk_col    (b_col),
    .wk_meta   (b_meta),
    .wk_pix    (b_pix),
    .wk_pop    (wq_pop),
    .out_cnt   (oq_cnt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue; the back end reserves a slot for every result in flight,
  // so a push here always finds room.
  bdr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (oq_rdata),
    .full    (),
    .empty   (out_empty),
    .count   (oq_cnt)
  );

  assign out_data = bdr_pkg::out_pix_t'(oq_rdata);

endmodule

`default_nettype wire

[bench/tb_box_downsample_rgb.sv]
`timescale 1ns / 100ps

module tb_box_downsample_rgb;

  // The block is built with its default sizes, and the predictor uses the same ones.
  localparam int DUT_MAX_WIDTH  = 4096;
  localparam int DUT_MAX_FACTOR = 8;
  localparam int FAC_PAD_W      = bdr_pkg::CFG_DATA_W - bdr_pkg::CFG_FACTOR_W;

  // Index 3 is not a register. A write there must be ignored and must not restart the frame.
  localparam logic [bdr_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  // The settle wait gives the pipeline time to empty before any register write
  // and at the end of the run.
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 950;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {POP_STEADY, POP_COIN, POP_SPARSE} pop_mode_t;
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  // One row of the directed table. It is either a register write or a pixel.
  // A pixel row may carry its result typed in by hand.
  typedef struct {
    row_kind_t                      kind;
    logic [bdr_pkg::CFG_IDX_W-1:0]  idx;
    logic [bdr_pkg::CFG_DATA_W-1:0] val;
    bdr_pkg::in_pix_t               px;
    bit                             typed;
    bdr_pkg::out_pix_t              res;
  } stim_row_t;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_push   = 1'b0;
  logic                           in_full;
  bdr_pkg::in_pix_t               in_data   = '0;
  logic                           out_empty;
  logic                           out_pop   = 1'b0;
  bdr_pkg::out_pix_t              out_data;
  logic                           cfg_we    = 1'b0;
  logic [bdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bdr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  box_downsample_rgb #(
    .MAX_WIDTH (DUT_MAX_WIDTH),
    .MAX_FACTOR(DUT_MAX_FACTOR)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor state. This is a private copy of the registers, the running
  // column sums and the raster position.
  logic [bdr_pkg::CFG_FACTOR_W-1:0] fac_reg;
  logic [bdr_pkg::CFG_DATA_W-1:0]   wid_reg;
  logic [bdr_pkg::HGT_W-1:0]        hgt_reg;
  int unsigned                      sum_red   [DUT_MAX_WIDTH];
  int unsigned                      sum_green [DUT_MAX_WIDTH];
  int unsigned                      sum_blue  [DUT_MAX_WIDTH];
  int unsigned                      src_col, src_row, col_in_blk, row_in_blk;

  bdr_pkg::out_pix_t awaited_pixels[$];
  stim_row_t         directed_rows[$];
  int                error_count  = 0;
  int                quiet_cycles = 0;
  bdr_pkg::out_pix_t oldest_pix;
  pop_mode_t         pop_mode     = POP_STEADY;
  int                mode_left    = 0;

  // A factor of zero acts as one. Larger factors saturate at the maximum.
  function automatic int unsigned eff_factor(input logic [bdr_pkg::CFG_FACTOR_W-1:0] v);
    if (v == 0) return 1;
    if (v > DUT_MAX_FACTOR) return DUT_MAX_FACTOR;
    return v;
  endfunction

  // The same rule applies to both image dimensions.
  function automatic int unsigned clamp_dim(input logic [bdr_pkg::CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < DUT_MAX_WIDTH; i++) begin
      sum_red[i]   = 0;
      sum_green[i] = 0;
      sum_blue[i]  = 0;
    end
    src_col    = 0;
    src_row    = 0;
    col_in_blk = 0;
    row_in_blk = 0;
  endfunction

  // Any write to a real register restarts the frame. The factor keeps only its low bits.
  function automatic void apply_reg(input logic [bdr_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bdr_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bdr_pkg::CFG_FACTOR: begin
        fac_reg = val[bdr_pkg::CFG_FACTOR_W-1:0];
        restart_frame();
      end
      bdr_pkg::CFG_WIDTH: begin
        wid_reg = val;
        restart_frame();
      end
      bdr_pkg::CFG_HEIGHT: begin
        hgt_reg = val;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // The predictor takes one source pixel and returns 1 when that pixel
  // completes a block. It then returns the averaged pixel in res.
  function automatic bit downsample_pixel(input bdr_pkg::in_pix_t px,
                                          output bdr_pkg::out_pix_t res);
    int unsigned f, w, h, oc, orow, blk;
    bit hit;
    f    = eff_factor(fac_reg);
    w    = clamp_dim(wid_reg, DUT_MAX_WIDTH);
    h    = clamp_dim(hgt_reg, bdr_pkg::MAX_HEIGHT);
    oc   = src_col / f;
    orow = src_row / f;
    hit  = 1'b0;
    res  = '0;
    // Pixels in the columns or rows left over past the last whole block are not summed.
    if (oc < w / f && orow < h / f && oc < DUT_MAX_WIDTH) begin
      sum_red[oc]   += px.red_in;
      sum_green[oc] += px.green_in;
      sum_blue[oc]  += px.blue_in;
      if (col_in_blk + 1 >= f && row_in_blk + 1 >= f) begin
        blk            = f * f;
        res.red_out    = 8'(sum_red[oc] / blk);
        res.green_out  = 8'(sum_green[oc] / blk);
        res.blue_out   = 8'(sum_blue[oc] / blk);
        res.out_column = 12'(oc);
        res.out_row    = 12'(orow);
        res.frame_done = (oc + 1 == w / f) && (orow + 1 == h / f);
        sum_red[oc]    = 0;
        sum_green[oc]  = 0;
        sum_blue[oc]   = 0;
        hit            = 1'b1;
      end
    end
    // Move to the next raster position. The frame wraps even when it is smaller than one block.
    if (src_col + 1 >= w) begin
      src_col    = 0;
      col_in_blk = 0;
      if (src_row + 1 >= h) begin
        src_row    = 0;
        row_in_blk = 0;
      end else begin
        src_row++;
        row_in_blk = (row_in_blk + 1 >= f) ? 0 : row_in_blk + 1;
      end
    end else begin
      src_col++;
      col_in_blk = (col_in_blk + 1 >= f) ? 0 : col_in_blk + 1;
    end
    return hit;
  endfunction

  function automatic void add_cfg(input logic [bdr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bdr_pkg::CFG_DATA_W-1:0] val);
    stim_row_t row;
    row      = '{kind: ROW_CFG, idx: idx, val: val, px: '0, typed: 1'b0, res: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pix(input bdr_pkg::in_pix_t px);
    stim_row_t row;
    row = '{kind: ROW_PIX, idx: '0, val: '0, px: px, typed: 1'b0, res: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_avg(input bdr_pkg::in_pix_t px, input bdr_pkg::out_pix_t res);
    stim_row_t row;
    row = '{kind: ROW_PIX, idx: '0, val: '0, px: px, typed: 1'b1, res: res};
    directed_rows.push_back(row);
  endfunction

  // This task offers one pixel and holds it until the transfer. The
  // expectation is queued at the transfer edge. in_push stays high after the
  // transfer, so the caller can send the next pixel back to back or lower it.
  task automatic send_pixel(input bdr_pkg::in_pix_t px, input bit typed,
                            input bdr_pkg::out_pix_t typed_res);
    bdr_pkg::out_pix_t res;
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full !== 1'b0);
    if (downsample_pixel(px, res)) begin
      awaited_pixels.push_back(typed ? typed_res : res);
    end
  endtask

  // This task stops sending and lets every expected result drain. It then
  // waits for the pipeline to empty, so that pixels with no result are also finished.
  task automatic go_quiet();
    in_push <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each write raises cfg_we, and the task lowers it again and lets the clock run
  // before it returns, so cfg_we is never lowered and raised again in the same step.
  task automatic write_reg(input logic [bdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdr_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver takes results and checks them, in modes that change at random.
  // In the steady mode it pops on every cycle; in the other two it pops at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (awaited_pixels.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result: r=%0d g=%0d b=%0d col=%0d row=%0d done=%0b",
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.out_column, out_data.out_row, out_data.frame_done);
        end else begin
          oldest_pix = awaited_pixels.pop_front();
          if (out_data.red_out    !== oldest_pix.red_out    ||
              out_data.green_out  !== oldest_pix.green_out  ||
              out_data.blue_out   !== oldest_pix.blue_out   ||
              out_data.out_column !== oldest_pix.out_column ||
              out_data.out_row    !== oldest_pix.out_row    ||
              out_data.frame_done !== oldest_pix.frame_done) begin
            error_count = error_count + 1;
            if (error_count <= REPORT_LIMIT)
              $display("mismatch: expected r=%0d g=%0d b=%0d col=%0d row=%0d done=%0b, %s",
                       oldest_pix.red_out, oldest_pix.green_out, oldest_pix.blue_out,
                       oldest_pix.out_column, oldest_pix.out_row, oldest_pix.frame_done,
                       $sformatf("got r=%0d g=%0d b=%0d col=%0d row=%0d done=%0b",
                                 out_data.red_out, out_data.green_out, out_data.blue_out,
                                 out_data.out_column, out_data.out_row,
                                 out_data.frame_done));
          end
        end
      end
      if (mode_left == 0) begin
        pop_mode  <= pop_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 128);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (pop_mode)
        POP_STEADY: out_pop <= 1'b1;
        POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
        default:    out_pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // The watchdog counts cycles in which no transfer happens on either side.
  // Honest idle stretches are short gaps, stalls and the settle waits, all far
  // below the limit, so reaching the limit means the block has hung.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_box_downsample_rgb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned ef, ew, eh, frame_len, phase_len, burst_left, lead_idx;
    int          rand_items, mode;
    logic [bdr_pkg::CFG_FACTOR_W-1:0] fac_val;
    logic [bdr_pkg::CFG_DATA_W-1:0]   fac_data, wid_val, hgt_val;
    bit               calm;
    logic [31:0]      r;
    bdr_pkg::in_pix_t px;

    fac_reg = bdr_pkg::FACTOR_RST;
    wid_reg = bdr_pkg::WIDTH_RST;
    hgt_reg = bdr_pkg::HEIGHT_RST;
    restart_frame();

    // Directed table. After reset the block works with factor 2 on a
    // 1024-wide image, so these first two pixels produce no result.
    add_pix({8'hff, 8'hff, 8'hff});
    add_pix({8'h00, 8'h00, 8'h00});
    // With factor 1 every pixel passes unchanged. The frame is two pixels of one row.
    add_cfg(bdr_pkg::CFG_FACTOR, 13'd1);
    add_cfg(bdr_pkg::CFG_WIDTH, 13'd2);
    add_cfg(bdr_pkg::CFG_HEIGHT, 13'd1);
    add_avg({8'hff, 8'h00, 8'hff}, {8'hff, 8'h00, 8'hff, 12'd0, 12'd0, 1'b0});
    add_avg({8'h00, 8'hff, 8'h00}, {8'h00, 8'hff, 8'h00, 12'd1, 12'd0, 1'b1});
    // A factor of zero acts as one.
    add_cfg(bdr_pkg::CFG_FACTOR, 13'd0);
    add_avg({8'h12, 8'h34, 8'h56}, {8'h12, 8'h34, 8'h56, 12'd0, 12'd0, 1'b0});
    // A write to the index past the last register does nothing, so the frame
    // position carries on to column 1.
    add_cfg(CFG_NONE, 13'h1fff);
    add_avg({8'h9a, 8'hbc, 8'hde}, {8'h9a, 8'hbc, 8'hde, 12'd1, 12'd0, 1'b1});
    // Factor 2 on a 3 by 2 image. The third column is dropped. The blue sum of
    // 3 over 4 samples truncates to 0.
    add_cfg(bdr_pkg::CFG_FACTOR, 13'd2);
    add_cfg(bdr_pkg::CFG_WIDTH, 13'd3);
    add_cfg(bdr_pkg::CFG_HEIGHT, 13'd2);
    add_pix({8'hff, 8'h00, 8'h01});
    add_pix({8'hff, 8'h00, 8'h01});
    add_pix({8'h55, 8'h55, 8'h55});
    add_pix({8'hff, 8'h00, 8'h01});
    add_avg({8'hff, 8'h00, 8'h00}, {8'hff, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1});
    add_pix({8'haa, 8'haa, 8'haa});
    // The image is smaller than one block, so nothing is emitted and the counters wrap.
    add_cfg(bdr_pkg::CFG_FACTOR, 13'd4);
    add_cfg(bdr_pkg::CFG_WIDTH, 13'd2);
    add_pix({8'h01, 8'h02, 8'h03});
    add_pix({8'hfd, 8'hfe, 8'hff});
    add_pix({8'h80, 8'h7f, 8'h80});
    add_pix({8'h7f, 8'h80, 8'h7f});
    // A width and height of zero act as one, so every pixel is a whole frame.
    add_cfg(bdr_pkg::CFG_FACTOR, 13'd1);
    add_cfg(bdr_pkg::CFG_WIDTH, 13'd0);
    add_cfg(bdr_pkg::CFG_HEIGHT, 13'd0);
    add_avg({8'h01, 8'h80, 8'hfe}, {8'h01, 8'h80, 8'hfe, 12'd0, 12'd0, 1'b1});
    add_pix({8'hfe, 8'h7f, 8'h01});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        go_quiet();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
      end
    end
    go_quiet();

    // Random part. Each phase picks a setting, writes it while the block is
    // idle, and then streams raster frames of random content. Most
    // images are small, so blocks complete often. A few phases use saturated
    // or random sizes, and in those the frame is cut short.
    rand_items = 0;
    while (rand_items < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       fac_val = 4'd0;
        1:       fac_val = 4'($urandom_range(9, 15));
        2:       fac_val = 4'd8;
        3:       fac_val = 4'd15;
        default: fac_val = 4'($urandom_range(1, 4));
      endcase
      ef = eff_factor(fac_val);
      fac_data = bdr_pkg::CFG_DATA_W'(fac_val);
      // The bits above the factor field must be ignored.
      if ($urandom_range(0, 3) == 0)
        fac_data[bdr_pkg::CFG_DATA_W-1:bdr_pkg::CFG_FACTOR_W] = FAC_PAD_W'($urandom);
      case ($urandom_range(0, 9))
        0:       wid_val = 13'd0;
        1:       wid_val = 13'h1fff;
        2:       wid_val = 13'($urandom_range(0, 8191));
        3:       wid_val = 13'd4096;
        default: wid_val = bdr_pkg::CFG_DATA_W'(ef * $urandom_range(1, 4)
                                                + $urandom_range(0, ef - 1));
      endcase
      case ($urandom_range(0, 9))
        0:       hgt_val = 13'd0;
        1:       hgt_val = 13'h1fff;
        2:       hgt_val = 13'($urandom_range(0, 8191));
        default: hgt_val = bdr_pkg::CFG_DATA_W'(ef * $urandom_range(1, 3)
                                                + $urandom_range(0, ef - 1));
      endcase
      ew        = clamp_dim(wid_val, DUT_MAX_WIDTH);
      eh        = clamp_dim(hgt_val, bdr_pkg::MAX_HEIGHT);
      frame_len = ew * eh;
      if (frame_len <= 250)
        phase_len = frame_len * $urandom_range(1, 3);
      else
        phase_len = $urandom_range(40, 200);
      if (phase_len > 300) phase_len = 300;
      if (phase_len > RANDOM_PIXELS - rand_items) phase_len = RANDOM_PIXELS - rand_items;

      go_quiet();
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, 13'($urandom_range(0, 8191)));
      lead_idx = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((lead_idx + k) % 3)
          bdr_pkg::CFG_FACTOR: write_reg(bdr_pkg::CFG_FACTOR, fac_data);
          bdr_pkg::CFG_WIDTH:  write_reg(bdr_pkg::CFG_WIDTH, wid_val);
          default:             write_reg(bdr_pkg::CFG_HEIGHT, hgt_val);
        endcase
      end

      // The content style is chosen per phase. Full-scale and all-or-nothing
      // channels drive the sums to their extremes. Tiny values exercise the truncation.
      mode       = $urandom_range(0, 5);
      calm       = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom;
        case (mode)
          1:       px = {8'hff, 8'hff, 8'hff};
          2:       px = {{8{r[0]}}, {8{r[1]}}, {8{r[2]}}};
          3:       px = {6'd0, r[1:0], 6'd0, r[3:2], 6'd0, r[5:4]};
          default: px = r[23:0];
        endcase
        send_pixel(px, 1'b0, '0);
        rand_items++;
        // The sender works in bursts. Between bursts it lowers in_push for a
        // random pause, except in calm phases, which stream without a break.
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (!calm) begin
            in_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
    end

    go_quiet();
    if (error_count == 0 && awaited_pixels.size() == 0)
      $display("tb_box_downsample_rgb: clean");
    else
      $display("tb_box_downsample_rgb: errors");
    $finish;
  end

endmodule

[files.f]
sv/bdr_pkg.sv
sv/bdr_fifo.sv
sv/bdr_front.sv
sv/bdr_back.sv
sv/box_downsample_rgb.sv
bench/tb_box_downsample_rgb.sv
